// ===== rtl/ddpg_pkg.sv =====
package ddpg_pkg;

    localparam int EXPLICIT_DEPTHS = 6;
    localparam int FRAC_BITS       = 16;
    localparam int LEN_W           = 8;
    localparam int TOP_W           = 3;
    localparam int DISC_W          = FRAC_BITS + 1;
    localparam int CONC_W          = 32;
    localparam int CFG_IDX_W       = 3;
    localparam int CFG_DATA_W      = 32;
    localparam int PROD_W          = CONC_W + 1;

    localparam logic [DISC_W-1:0] ONE_Q      = DISC_W'(1) << FRAC_BITS;
    localparam logic [DISC_W-1:0] DISC_RESET = ONE_Q >> 1;
    localparam logic [TOP_W-1:0]  TOP_MAX    = TOP_W'(EXPLICIT_DEPTHS - 1);

    localparam logic [CFG_IDX_W-1:0] REG_TOP_DEPTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DISC_FIRST = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ALPHA      = 3'd7;

    typedef struct packed {
        logic [LEN_W-1:0] node_length;
        logic             path_start;
    } node_item_t;

    typedef struct packed {
        logic [DISC_W-1:0] node_discount;
        logic [CONC_W-1:0] node_concentration;
    } res_item_t;

    typedef struct packed {
        logic [TOP_W-1:0]                         top_depth;
        logic [EXPLICIT_DEPTHS-1:0][DISC_W-1:0]   discount;
        logic [CONC_W-1:0]                        alpha;
    } cfg_t;

endpackage

// ===== rtl/depth_discount_path_generator.sv =====
// Depth discount generator for the nodes of one context-tree path.
// The node channel (node_valid, node_stall, node_item) takes one node at a
// time: its context length and a flag that marks the first node of a path.
// The result channel (res_valid, res_stall, res_item) returns one item per
// node with the node's discount (Q1.16) and concentration (Q16.16).
// The configuration channel (cfg_valid, cfg_ready, cfg_index, cfg_data) is
// always ready and writes top_depth, the six depth discounts and alpha.
// One shared 32 by 17 multiplier does all the work, one product per cycle
// while a node is in work and no stalled result holds it back. The result
// register is loaded in the concentration step, after E explicit steps for
// the depths between parent and node and R repeat steps for the depths
// beyond top_depth that reuse the top discount. A new node can be accepted
// in the cycle after the previous result has been loaded, not before.
// If the receiver stalls, the result waits in its register; the block can
// accept and work on the next node, then waits before loading its result.
// Reset sets top_depth to zero, every discount to one half, alpha to zero,
// forgets the parent, and clears the running concentration.
module depth_discount_path_generator
    import ddpg_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  node_valid,
    output logic                  node_stall,
    input  node_item_t            node_item,
    output logic                  res_valid,
    input  logic                  res_stall,
    output res_item_t             res_item,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t             cfg_reg;
    logic [TOP_W-1:0] disc_idx;

    assign cfg_ready = 1'b1;
    assign disc_idx  = cfg_index - REG_DISC_FIRST;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.top_depth <= '0;
            cfg_reg.alpha     <= '0;
            for (int k = 0; k < EXPLICIT_DEPTHS; k++)
            begin
                cfg_reg.discount[k] <= DISC_RESET;
            end
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_TOP_DEPTH: cfg_reg.top_depth <= cfg_data[TOP_W-1:0];
                REG_ALPHA:     cfg_reg.alpha     <= cfg_data[CONC_W-1:0];
                default:       cfg_reg.discount[disc_idx] <= cfg_data[DISC_W-1:0];
            endcase
        end
    end

    ddpg_seq u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .node_valid (node_valid),
        .node_stall (node_stall),
        .node_item  (node_item),
        .res_valid  (res_valid),
        .res_stall  (res_stall),
        .res_item   (res_item)
    );

`ifndef SYNTH
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (node_valid && !node_stall) |=> node_stall)
        else $error("block took a node item without going busy");

    a_disc_range: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (res_item.node_discount <= ONE_Q))
        else $error("discount above one");

    a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid) |-> $past(node_stall))
        else $error("result item appeared without a node item in progress");
`endif

endmodule

// ===== rtl/ddpg_mul.sv =====
module ddpg_mul
    import ddpg_pkg::*;
(
    input  logic [CONC_W-1:0] a,
    input  logic [DISC_W-1:0] b,
    output logic [PROD_W-1:0] prod
);

    logic [CONC_W+DISC_W-1:0] full;

    assign full = {{DISC_W{1'b0}}, a} * {{CONC_W{1'b0}}, b};
    assign prod = full[FRAC_BITS +: PROD_W];

endmodule

// ===== rtl/ddpg_seq.sv =====
module ddpg_seq
    import ddpg_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cfg_t       cfg,
    input  logic       node_valid,
    output logic       node_stall,
    input  node_item_t node_item,
    output logic       res_valid,
    input  logic       res_stall,
    output res_item_t  res_item
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_EXPL = 2'd1;
    localparam logic [1:0] ST_REP  = 2'd2;
    localparam logic [1:0] ST_CONC = 2'd3;

    logic [1:0]        state_reg, state_next;
    logic              has_parent_reg, has_parent_next;
    logic [LEN_W-1:0]  parent_len_reg, parent_len_next;
    logic [CONC_W-1:0] conc_reg, conc_next;
    logic [DISC_W-1:0] d_reg, d_next;
    logic [TOP_W-1:0]  i_reg, i_next;
    logic [TOP_W-1:0]  last_reg, last_next;
    logic [LEN_W-1:0]  cnt_reg, cnt_next;
    logic              out_valid_reg, out_valid_next;
    res_item_t         out_item_reg, out_item_next;

    logic              accept;
    logic              out_free;
    logic [TOP_W-1:0]  top_eff;
    logic              has_p;
    logic [LEN_W-1:0]  plen;
    logic [LEN_W:0]    first;
    logic [TOP_W-1:0]  last;
    logic [LEN_W-1:0]  top_ext;
    logic [LEN_W-1:0]  base;
    logic [LEN_W-1:0]  len;
    logic              expl_go;
    logic              rep_go;
    logic [CONC_W-1:0] mul_a;
    logic [DISC_W-1:0] mul_b;
    logic [PROD_W-1:0] mul_p;

    function automatic logic [DISC_W-1:0] clamp_disc(input logic [DISC_W-1:0] v);
        clamp_disc = (v > ONE_Q) ? ONE_Q : v;
    endfunction

    assign node_stall = (state_reg != ST_IDLE);
    assign accept     = node_valid && !node_stall;
    assign out_free   = !out_valid_reg || !res_stall;
    assign res_valid  = out_valid_reg;
    assign res_item   = out_item_reg;

    assign top_eff = (cfg.top_depth > TOP_MAX) ? TOP_MAX : cfg.top_depth;
    assign top_ext = {{(LEN_W-TOP_W){1'b0}}, top_eff};
    assign len     = node_item.node_length;
    assign has_p   = !node_item.path_start && has_parent_reg;
    assign plen    = node_item.path_start ? '0 : parent_len_reg;
    assign first   = has_p ? ({1'b0, plen} + (LEN_W+1)'(1)) : '0;
    assign last    = (len < top_ext) ? len[TOP_W-1:0] : top_eff;
    assign base    = (has_p && (plen > top_ext)) ? plen : top_ext;
    assign expl_go = (first <= {{(LEN_W+1-TOP_W){1'b0}}, last});
    assign rep_go  = (len > base);

    always_comb
    begin
        if (state_reg == ST_CONC)
        begin
            mul_a = conc_reg;
            mul_b = d_reg;
        end
        else
        begin
            mul_a = {{(CONC_W-DISC_W){1'b0}}, d_reg};
            mul_b = (state_reg == ST_EXPL) ? clamp_disc(cfg.discount[i_reg])
                                           : clamp_disc(cfg.discount[top_eff]);
        end
    end

    ddpg_mul u_mul (
        .a    (mul_a),
        .b    (mul_b),
        .prod (mul_p)
    );

    always_comb
    begin
        state_next      = state_reg;
        has_parent_next = has_parent_reg;
        parent_len_next = parent_len_reg;
        conc_next       = conc_reg;
        d_next          = d_reg;
        i_next          = i_reg;
        last_next       = last_reg;
        cnt_next        = cnt_reg;
        out_valid_next  = out_valid_reg && res_stall;
        out_item_next   = out_item_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (node_item.path_start)
                    begin
                        conc_next = cfg.alpha;
                    end
                    has_parent_next = 1'b1;
                    parent_len_next = len;
                    d_next          = ONE_Q;
                    i_next          = first[TOP_W-1:0];
                    last_next       = last;
                    cnt_next        = rep_go ? (len - base) : '0;
                    state_next      = expl_go ? ST_EXPL : (rep_go ? ST_REP : ST_CONC);
                end
            end
            ST_EXPL:
            begin
                d_next = mul_p[DISC_W-1:0];
                i_next = i_reg + TOP_W'(1);
                if (i_reg == last_reg)
                begin
                    state_next = (cnt_reg != '0) ? ST_REP : ST_CONC;
                end
            end
            ST_REP:
            begin
                d_next   = mul_p[DISC_W-1:0];
                cnt_next = cnt_reg - LEN_W'(1);
                if (cnt_reg == LEN_W'(1))
                begin
                    state_next = ST_CONC;
                end
            end
            ST_CONC:
            begin
                if (out_free)
                begin
                    out_valid_next                   = 1'b1;
                    out_item_next.node_discount      = d_reg;
                    out_item_next.node_concentration = conc_reg;
                    conc_next                        = mul_p[CONC_W-1:0];
                    state_next                       = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            has_parent_reg <= 1'b0;
            parent_len_reg <= '0;
            conc_reg       <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            has_parent_reg <= has_parent_next;
            parent_len_reg <= parent_len_next;
            conc_reg       <= conc_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        d_reg        <= d_next;
        i_reg        <= i_next;
        last_reg     <= last_next;
        cnt_reg      <= cnt_next;
        out_item_reg <= out_item_next;
    end

endmodule
